@@ rtl/mft_pkg.sv @@
// Package for the message fragment tracker.
// Holds the request and response payloads, the count encoding, status codes and
// the command and status bundles between the controller and the datapath.
package mft_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 5;

    localparam int ID_W    = 32;
    localparam int EXP_W   = 4;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 3;

    typedef logic signed [CNT_W-1:0] t_count;

    // Special count values: a complete message and a processed message.
    localparam t_count CNT_PROCESSED = -7'sd1;
    localparam t_count CNT_COMPLETE  = -7'sd2;
    localparam t_count CNT_MAX       = 7'sd63;
    localparam t_count CNT_FIRST     = 7'sd1;

    typedef enum logic [0:0] {
        OP_FRAGMENT = 1'b0,
        OP_RETIRE   = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_NEW       = 3'd0,
        ST_PROCESSED = 3'd1,
        ST_COMPLETE  = 3'd2,
        ST_ADDED     = 3'd3,
        ST_NONE      = 3'd4,
        ST_RETIRED   = 3'd5
    } t_status;

    typedef struct packed {
        logic              op;
        logic [ID_W-1:0]   message_id;
        logic [EXP_W-1:0]  expected_fragments;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   result_id;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic frag;   // apply a fragment to the table and write its response
        logic find;   // look for the first complete entry
        logic mark;   // mark the first entry holding the found id as processed
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;     // operation of the captured request
        logic found;  // a complete entry exists
    } t_sts;

endpackage

@@ rtl/mft_stream_if.sv @@
// Valid/ready stream interface used for the request and response channels.
// The payload type is given at instantiation; depends on nothing else.
interface mft_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/message_fragment_tracker.sv @@
// Message fragment tracker, top level.
// A fragment request is answered in the controller's evaluate step; a retire
// request adds a mark step over the register table when a complete message
// is found. The controller takes no new request until it is back in idle,
// and both steps wait while the response register is full and not taken.
// Synchronous active-low reset clears all ids, counts and the write pointer.
module message_fragment_tracker #(
    parameter int TABLE_ENTRIES = mft_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mft_stream_if.sink   i_req,
    mft_stream_if.source o_rsp
);

    // The table holds one id and one signed count per entry. A count of minus
    // two marks a complete message, minus one a processed one. A fragment
    // request updates every matching entry up to the first processed match;
    // an unknown id is written at the round-robin pointer with a count of one.
    // A retire request first looks for a complete entry, then, in a second
    // step, marks the first entry holding that id as processed.

    mft_pkg::t_cmd cmd;
    mft_pkg::t_sts sts;
    mft_pkg::t_rsp rsp;

    // The controller accepts a request only when idle; a response waiting in
    // the output register does not hold off the next request.
    mft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mft_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.payload),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (rsp)
    );

    assign o_rsp.payload = rsp;

endmodule

@@ rtl/mft_ctrl.sv @@
// Controller of the message fragment tracker: sequences load, evaluation and
// marking, and owns the response valid flag. Depends on mft_pkg.
module mft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  logic           i_rsp_ready,
    output logic           o_rsp_valid,
    input  mft_pkg::t_sts  i_sts,
    output mft_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_MARK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    logic   out_free;

    // The response register may be overwritten when empty or being taken.
    assign out_free    = !r_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_req_valid;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    if (i_sts.op == mft_pkg::OP_FRAGMENT) begin
                        o_cmd.frag = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.find = 1'b1;
                        n_state    = i_sts.found ? S_MARK : S_IDLE;
                    end
                end
            end
            S_MARK: begin
                if (out_free) begin
                    o_cmd.mark = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid && !i_rsp_ready;
        if (o_cmd.frag || (o_cmd.find && !i_sts.found) || o_cmd.mark) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

@@ rtl/mft_datapath.sv @@
// Datapath of the message fragment tracker: the id and count table, the
// round-robin pointer, the captured request and the response register.
// Depends on mft_pkg.
module mft_datapath #(
    parameter int TABLE_ENTRIES = mft_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mft_pkg::t_req  i_req,
    input  mft_pkg::t_cmd  i_cmd,
    output mft_pkg::t_sts  o_sts,
    output mft_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [mft_pkg::ID_W-1:0] r_entry_id    [TABLE_ENTRIES];
    logic [mft_pkg::ID_W-1:0] n_entry_id    [TABLE_ENTRIES];
    mft_pkg::t_count          r_entry_count [TABLE_ENTRIES];
    mft_pkg::t_count          n_entry_count [TABLE_ENTRIES];
    logic [IDX_W-1:0]         r_wp;
    logic [IDX_W-1:0]         n_wp;
    mft_pkg::t_req            r_req;
    logic [mft_pkg::ID_W-1:0] r_found_id;
    logic [mft_pkg::ID_W-1:0] found_id;
    logic                     found;
    mft_pkg::t_rsp            r_rsp;
    mft_pkg::t_rsp            n_rsp;

    // First complete entry, for a retire request.
    always_comb begin
        found    = 1'b0;
        found_id = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (!found && r_entry_count[k] == mft_pkg::CNT_COMPLETE) begin
                found    = 1'b1;
                found_id = r_entry_id[k];
            end
        end
    end

    assign o_sts.op    = r_req.op;
    assign o_sts.found = found;
    assign o_rsp       = r_rsp;

    // Table update. Every entry is compared in parallel; the scan order only
    // matters for where a processed match cuts it short and for the status.
    always_comb begin
        logic                      hit;
        logic                      stopped;
        logic                      any_match;
        logic                      marked;
        logic [mft_pkg::STAT_W-1:0] frag_status;
        mft_pkg::t_count           inc;
        mft_pkg::t_count           expected;

        n_entry_id    = r_entry_id;
        n_entry_count = r_entry_count;
        n_wp          = r_wp;
        n_rsp         = r_rsp;
        stopped       = 1'b0;
        any_match     = 1'b0;
        marked        = 1'b0;
        frag_status   = mft_pkg::ST_NEW;
        expected      = $signed({3'b000, r_req.expected_fragments});

        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            hit = (r_entry_id[k] == r_req.message_id);
            inc = (r_entry_count[k] < mft_pkg::CNT_MAX) ? r_entry_count[k] + 7'sd1
                                                        : r_entry_count[k];
            if (hit && !stopped) begin
                any_match = 1'b1;
                if (r_entry_count[k] == mft_pkg::CNT_PROCESSED) begin
                    frag_status = mft_pkg::ST_PROCESSED;
                    stopped     = 1'b1;
                end else if (inc == expected) begin
                    frag_status = mft_pkg::ST_COMPLETE;
                    if (i_cmd.frag) begin
                        n_entry_count[k] = mft_pkg::CNT_COMPLETE;
                    end
                end else begin
                    frag_status = mft_pkg::ST_ADDED;
                    if (i_cmd.frag) begin
                        n_entry_count[k] = inc;
                    end
                end
            end
        end

        // No entry knows the id: it takes the slot at the round-robin pointer.
        if (i_cmd.frag && !any_match) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (IDX_W'(k) == r_wp) begin
                    n_entry_id[k]    = r_req.message_id;
                    n_entry_count[k] = mft_pkg::CNT_FIRST;
                end
            end
            n_wp = (r_wp == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : r_wp + 1'b1;
        end

        // Retirement marks the first entry with the found id, which need not be
        // the complete entry itself.
        if (i_cmd.mark) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (!marked && r_entry_id[k] == r_found_id) begin
                    marked           = 1'b1;
                    n_entry_count[k] = mft_pkg::CNT_PROCESSED;
                end
            end
        end

        if (i_cmd.frag) begin
            n_rsp.status    = frag_status;
            n_rsp.result_id = '0;
        end else if (i_cmd.find && !found) begin
            n_rsp.status    = mft_pkg::ST_NONE;
            n_rsp.result_id = '0;
        end else if (i_cmd.mark) begin
            n_rsp.status    = mft_pkg::ST_RETIRED;
            n_rsp.result_id = r_found_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_entry_id[k]    <= '0;
                r_entry_count[k] <= '0;
            end
            r_wp <= '0;
        end else begin
            r_entry_id    <= n_entry_id;
            r_entry_count <= n_entry_count;
            r_wp          <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.find) begin
            r_found_id <= found_id;
        end
        r_rsp <= n_rsp;
    end

endmodule
